### hw/rtl/srdc_pkg.sv
// shared types, constants and helpers for the sensor report decrypt/check block
// no dependencies
`default_nettype none

package srdc_pkg;

    localparam int unsigned NUM_BYTES = 8;
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned DATA_W    = 64;

    // register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_SESSION_KEY = 4'h0;

    localparam logic [7:0] END_MARK_CODE = 8'h0d;

    typedef logic [7:0] byte_t;
    typedef byte_t [NUM_BYTES-1:0] byte_vec_t;

    // destination position of received byte i
    localparam logic [2:0] ORDER_TAB [NUM_BYTES] = '{3'd2, 3'd4, 3'd0, 3'd7,
                                                     3'd1, 3'd6, 3'd5, 3'd3};

    localparam byte_t SALT_TAB [NUM_BYTES] = '{8'h48, 8'h74, 8'h65, 8'h6D,
                                               8'h70, 8'h39, 8'h39, 8'h65};

    typedef struct packed {
        byte_t cipher_byte0;
        byte_t cipher_byte1;
        byte_t cipher_byte2;
        byte_t cipher_byte3;
        byte_t cipher_byte4;
        byte_t cipher_byte5;
        byte_t cipher_byte6;
        byte_t cipher_byte7;
    } in_item_t;

    typedef struct packed {
        byte_t       tag;
        logic [15:0] reading;
        byte_t       check_byte;
        byte_t       end_mark;
        logic        valid_res;
    } out_item_t;

    function automatic byte_t nib_swap(input byte_t v);
        return {v[3:0], v[7:4]};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/srdc_cfg.sv
// apb register file holding the 64-bit session key
// depends on srdc_pkg
`default_nettype none

module srdc_cfg
    import srdc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output logic      [DATA_W-1:0] session_key
);

    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] key_next;
    logic              key_hit;

    // registers sit on 8-byte boundaries, so only bit 3 and up select
    assign key_hit = (paddr[ADDR_W-1:3] == ADDR_SESSION_KEY[ADDR_W-1:3]);

    always_comb
    begin
        key_next = key_reg;
        if (psel && penable && pwrite && key_hit)
        begin
            key_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign prdata      = key_hit ? key_reg : '0;
    assign pready      = 1'b1;
    assign session_key = key_reg;

endmodule

`default_nettype wire

### hw/rtl/srdc_decode.sv
// combinational report decode: permute, key xor, 3-bit rotate, salt subtract, check
// depends on srdc_pkg
`default_nettype none

module srdc_decode
    import srdc_pkg::*;
(
    input  wire in_item_t          item,
    input  wire logic [DATA_W-1:0] session_key,
    output out_item_t              result
);

    byte_vec_t raw;
    byte_vec_t perm;
    byte_vec_t mixed;
    byte_vec_t plain;
    byte_t     sum;

    assign raw = {item.cipher_byte7, item.cipher_byte6, item.cipher_byte5,
                  item.cipher_byte4, item.cipher_byte3, item.cipher_byte2,
                  item.cipher_byte1, item.cipher_byte0};

    always_comb
    begin
        perm = '0;
        for (int i = 0; i < NUM_BYTES; i++)
        begin
            perm[ORDER_TAB[i]] = raw[i];
        end
        for (int i = 0; i < NUM_BYTES; i++)
        begin
            mixed[i] = perm[i] ^ session_key[8*i +: 8];
        end
        // rotate right by 3 across the whole word, byte 0 takes bits from byte 7
        for (int i = 0; i < NUM_BYTES; i++)
        begin
            plain[i] = {mixed[(i + NUM_BYTES - 1) % NUM_BYTES][2:0], mixed[i][7:3]}
                       - nib_swap(SALT_TAB[i]);
        end
    end

    assign sum = plain[0] + plain[1] + plain[2];

    assign result.tag        = plain[0];
    assign result.reading    = {plain[1], plain[2]};
    assign result.check_byte = plain[3];
    assign result.end_mark   = plain[4];
    assign result.valid_res  = (plain[4] == END_MARK_CODE) && (sum == plain[3]);

endmodule

`default_nettype wire

### hw/rtl/sensor_report_decrypt_check_core.sv
// top level of the sensor report decrypt/check block
// depends on srdc_pkg, srdc_cfg, srdc_decode
`default_nettype none

// Decodes one 8-byte encrypted sensor report per item into tag, 16-bit reading,
// checksum byte, end mark and a validity flag. An accepted report sits in an input
// register, passes through the decode logic and lands in the result register when
// that register is free; one report can be taken every cycle while the result side
// keeps up. The session key is written through the APB port at byte address 0 and
// should only change while no report is in flight.
module sensor_report_decrypt_check_core
    import srdc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    logic [DATA_W-1:0] session_key;
    in_item_t          item_reg;
    logic              item_vld_reg;
    out_item_t         res_reg;
    logic              res_vld_reg;
    out_item_t         res_next;
    logic              res_take;

    srdc_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .session_key (session_key)
    );

    srdc_decode u_decode (
        .item        (item_reg),
        .session_key (session_key),
        .result      (res_next)
    );

    // result register frees up when empty or being drained
    assign res_take = !res_vld_reg || out_ready;
    assign in_ready = !item_vld_reg || res_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                item_vld_reg <= in_valid;
            end
            if (res_take)
            begin
                res_vld_reg <= item_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_data;
        end
        if (res_take && item_vld_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = res_vld_reg;
    assign out_data  = res_reg;

endmodule

`default_nettype wire
